/* design/tpis_pkg.sv */
// ----------------------------------------------------------------------------
// tpis_pkg
// Shared types and constants for the tabular pdf inverse sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tpis_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = 9;
	localparam int VALUE_WIDTH = 32;

	// Q1.31 cdf constants; tolerances in LSB
	localparam logic [31:0] CDF_ONE   = 32'h8000_0000;
	localparam logic [31:0] TOL_SMALL = 32'd21;
	localparam logic [31:0] TOL_LARGE = 32'd2147;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_TABLE = 2'd1;
	localparam logic [1:0] STAT_BAD_STATE = 2'd2;

	localparam logic [1:0] MODE_DISCRETE = 2'd0;
	localparam logic [1:0] MODE_HIST     = 2'd1;
	localparam logic [1:0] MODE_LINLIN   = 2'd2;

	localparam logic [1:0] CFG_POINT_COUNT    = 2'd0;
	localparam logic [1:0] CFG_DISCRETE_COUNT = 2'd1;
	localparam logic [1:0] CFG_INTERP_MODE    = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_CHECK, S_SCAN, S_DECIDE, S_FETCH1, S_FETCH2, S_PREP,
		S_MUL_SQ, S_DIV_Q, S_DISC, S_SQRT, S_DEN, S_DIV_OFF, S_DIV_HIST, S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RES_BAD_TABLE, RES_BAD_STATE, RES_HIT, RES_LAST, RES_CONT
	} res_t;

	typedef enum logic [1:0] {DIV_HIST, DIV_SLOPE, DIV_OFF} div_sel_t;

	typedef enum logic [1:0] {RD_SCAN, RD_LO, RD_HI} rd_sel_t;

	typedef struct packed {
		logic     capture;
		logic     load;
		logic     scan_start;
		logic     scan_run;
		rd_sel_t  rd_sel;
		logic     lo_fix;
		logic     fetch_lo;
		logic     fetch_hi;
		logic     mul_prod;
		logic     mul_sq;
		logic     div_start;
		div_sel_t div_sel;
		logic     make_disc;
		logic     sqrt_start;
		logic     make_den;
		logic     take_quot;
		logic     off_zero;
		logic     emit;
		res_t     res;
	} cmd_t;

	typedef struct packed {
		logic quick_bad;
		logic scan_done;
		logic scan_bad;
		logic hit;
		logic all_disc;
		logic prob_pos;
		logic use_hist;
		logic p0_zero;
		logic w_zero;
		logic falls;
		logic disc_neg;
		logic den_zero;
		logic div_done;
		logic sqrt_done;
	} stat_t;

endpackage

`default_nettype wire

/* design/tpis_div.sv */
// ----------------------------------------------------------------------------
// tpis_div
// Restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpis_div import tpis_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [32:0] divisor,
	output logic             done,
	output logic [63:0]      quot,
	output logic [32:0]      rem
);

	logic [63:0] dvd_q;
	logic [32:0] dvs_q;
	logic [32:0] rem_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;
	logic        ge;
	logic [33:0] diff;

	// one quotient bit per step, shifted into the dividend register
	assign trial = {rem_q, dvd_q[63]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : trial[32:0];
			dvd_q <= {dvd_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* design/tpis_sqrt.sv */
// ----------------------------------------------------------------------------
// tpis_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpis_sqrt import tpis_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);

	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic        ge;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign ge    = {1'b0, v_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// digit-by-digit root, bit walks down from 2^62
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (ge) begin
				v_q <= v_q - trial[63:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

`default_nettype wire

/* design/tpis_dp.sv */
// ----------------------------------------------------------------------------
// tpis_dp
// Datapath: config registers, point tables, cdf scan, bin inversion, result.
// ----------------------------------------------------------------------------
`default_nettype none

module tpis_dp import tpis_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output stat_t                   stat,
	input  wire logic               cfg_valid,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [8:0]         cfg_data,
	input  wire logic [7:0]         entry_index,
	input  wire logic signed [31:0] entry_abscissa,
	input  wire logic [31:0]        entry_density,
	input  wire logic [31:0]        entry_cumulative,
	input  wire logic [31:0]        uniform_draw,
	output logic [1:0]              status,
	output logic signed [31:0]      sample_value,
	output logic [7:0]              sample_index
);

	// configuration
	logic [CNT_W-1:0] pc_q, dc_q;
	logic [1:0]       mode_q;

	// captured request
	logic [IDX_W-1:0] cap_idx_q;
	logic [31:0]      cap_x_q, cap_p_q, cap_c_q, xi_q;

	// table state
	logic [CNT_W-1:0] pl_q;
	logic             bad_q;
	logic [31:0]      last_c_q;
	logic [31:0]      x_mem [TABLE_DEPTH];
	logic [31:0]      p_mem [TABLE_DEPTH];
	logic [31:0]      c_mem [TABLE_DEPTH];
	logic [31:0]      rd_x_q, rd_p_q, rd_c_q;
	logic [IDX_W-1:0] rd_addr;

	// scan
	logic [CNT_W-1:0] rd_cnt_q;
	logic             rd_issue;
	logic             ev_vld_s1;
	logic [IDX_W-1:0] ev_idx_s1;
	logic [31:0]      prev_x_q, prev_c_q;
	logic             sbad_q, hit_q, run_q, done_q;
	logic [IDX_W-1:0] hit_idx_q, lo_q, lo_c;
	logic [31:0]      hit_x_q, last_x_q;

	// bin arithmetic
	logic [31:0]      x0_q, x1_q, p0_q, p1_q, c0_q;
	logic [63:0]      prod_q, sq_q, disc_q;
	logic             neg_q;
	logic [32:0]      den_q, off_q;

	// output
	logic [1:0]       status_q;
	logic [31:0]      value_q;
	logic [IDX_W-1:0] index_q;

	// ---------------- configuration writes ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= 9'd2;
			dc_q   <= 9'd0;
			mode_q <= MODE_LINLIN;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POINT_COUNT:    pc_q   <= cfg_data;
				CFG_DISCRETE_COUNT: dc_q   <= cfg_data;
				CFG_INTERP_MODE:    mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// ---------------- request capture ----------------
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_idx_q <= entry_index;
			cap_x_q   <= entry_abscissa;
			cap_p_q   <= entry_density;
			cap_c_q   <= entry_cumulative;
			xi_q      <= uniform_draw;
		end
	end

	// ---------------- table load ----------------
	logic [CNT_W-1:0] eff_pl;
	logic             wr_ok, cdf_bad;

	assign eff_pl  = (cap_idx_q == '0) ? '0 : pl_q;
	assign wr_ok   = {1'b0, cap_idx_q} == eff_pl;
	assign cdf_bad = ({1'b0, cap_c_q} > ({1'b0, CDF_ONE} + {1'b0, TOL_LARGE}))
		|| ((cap_idx_q != '0) && (cap_c_q < last_c_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_q  <= '0;
			bad_q <= 1'b0;
		end else if (cmd.load) begin
			if (!wr_ok) begin
				bad_q <= 1'b1;
			end else begin
				bad_q <= ((cap_idx_q == '0) ? 1'b0 : bad_q) | cdf_bad;
				pl_q  <= {1'b0, cap_idx_q} + 9'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			x_mem[cap_idx_q] <= cap_x_q;
			p_mem[cap_idx_q] <= cap_p_q;
			c_mem[cap_idx_q] <= cap_c_q;
			last_c_q         <= cap_c_q;
		end
	end

	// ---------------- table read port ----------------
	always_comb begin
		case (cmd.rd_sel)
			RD_SCAN: rd_addr = rd_cnt_q[IDX_W-1:0];
			RD_LO:   rd_addr = lo_c;
			RD_HI:   rd_addr = lo_q + 8'd1;
			default: rd_addr = rd_cnt_q[IDX_W-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		rd_x_q <= x_mem[rd_addr];
		rd_p_q <= p_mem[rd_addr];
		rd_c_q <= c_mem[rd_addr];
	end

	// ---------------- quick table checks ----------------
	logic mode_ok;
	assign mode_ok = (mode_q == MODE_HIST) || (mode_q == MODE_LINLIN)
		|| ((mode_q == MODE_DISCRETE) && (dc_q == pc_q));

	assign stat.quick_bad = bad_q || (pc_q == '0) || (pc_q > 9'd256) || (pc_q > pl_q)
		|| !mode_ok || (dc_q > pc_q) || ((dc_q < pc_q) && ((pc_q - dc_q) < 9'd2));

	// ---------------- scan: one entry per cycle ----------------
	logic signed [31:0] xa, xb;
	logic [31:0]        cb, cdiff, cdist;
	logic [CNT_W-1:0]   ev_ext;
	logic               after_nd, is_last, pair_bad, first_bad, last_bad;

	assign rd_issue = cmd.scan_run && (rd_cnt_q < pc_q);
	assign xa       = prev_x_q;
	assign xb       = rd_x_q;
	assign cb       = rd_c_q;
	assign cdiff    = (cb >= prev_c_q) ? (cb - prev_c_q) : (prev_c_q - cb);
	assign cdist    = (cb >= CDF_ONE) ? (cb - CDF_ONE) : (CDF_ONE - cb);
	assign ev_ext   = {1'b0, ev_idx_s1};
	assign after_nd = ev_ext > dc_q;
	assign is_last  = ev_ext == (pc_q - 9'd1);
	assign pair_bad = after_nd && (((xb < xa) && ((prev_c_q < (CDF_ONE - TOL_SMALL))
		|| (cb < (CDF_ONE - TOL_SMALL)))) || ((xb == xa) && (cdiff > TOL_SMALL)));
	assign first_bad = (dc_q == '0) && (ev_idx_s1 == '0) && (cb > TOL_SMALL);
	assign last_bad  = is_last && (cdist > TOL_LARGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			rd_cnt_q  <= '0;
		end else begin
			ev_vld_s1 <= rd_issue;
			if (cmd.scan_start) begin
				rd_cnt_q <= '0;
				done_q   <= 1'b0;
			end else begin
				if (rd_issue)
					rd_cnt_q <= rd_cnt_q + 9'd1;
				if (ev_vld_s1 && is_last)
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (cmd.scan_start) begin
			sbad_q <= 1'b0;
			hit_q  <= 1'b0;
			run_q  <= 1'b1;
			lo_q   <= dc_q[IDX_W-1:0];
		end else if (ev_vld_s1) begin
			sbad_q   <= sbad_q | pair_bad | first_bad | last_bad;
			prev_x_q <= xb;
			prev_c_q <= cb;
			if (is_last)
				last_x_q <= xb;
			// discrete line: first with xi < cdf
			if ((ev_ext < dc_q) && !hit_q && ({1'b0, xi_q} < {cb, 1'b0})) begin
				hit_q     <= 1'b1;
				hit_idx_q <= ev_idx_s1;
				hit_x_q   <= xb;
			end
			// continuous bin walk while cdf[lo+1] <= xi
			if (after_nd && run_q) begin
				if ({cb, 1'b0} <= {1'b0, xi_q})
					lo_q <= ev_idx_s1;
				else
					run_q <= 1'b0;
			end
		end else if (cmd.lo_fix) begin
			lo_q <= lo_c;
		end
	end

	// last bin limit
	logic [CNT_W-1:0] pc_m2;
	assign pc_m2 = pc_q - 9'd2;
	assign lo_c  = (({1'b0, lo_q} + 9'd1) >= pc_q) ? pc_m2[IDX_W-1:0] : lo_q;

	assign stat.scan_done = done_q;
	assign stat.scan_bad  = sbad_q;
	assign stat.hit       = hit_q;
	assign stat.all_disc  = dc_q == pc_q;

	// ---------------- bin fetch ----------------
	always_ff @(posedge clk) begin
		if (cmd.fetch_lo) begin
			x0_q <= rd_x_q;
			p0_q <= rd_p_q;
			c0_q <= rd_c_q;
		end
		if (cmd.fetch_hi) begin
			x1_q <= rd_x_q;
			p1_q <= rd_p_q;
		end
	end

	// ---------------- bin terms ----------------
	logic [33:0]        prob;
	logic [31:0]        pv, mslope;
	logic signed [32:0] w;
	logic [32:0]        aw;
	logic               w_neg, falls, rising;

	assign prob   = {2'b00, xi_q} - {1'b0, c0_q, 1'b0};
	assign pv     = prob[31:0];
	assign w      = {x1_q[31], x1_q} - {x0_q[31], x0_q};
	assign w_neg  = w[32];
	assign aw     = w_neg ? (33'd0 - w) : w;
	assign falls  = p1_q < p0_q;
	assign mslope = falls ? (p0_q - p1_q) : (p1_q - p0_q);
	assign rising = falls == w_neg;

	assign stat.prob_pos = !prob[33] && (prob != '0);
	assign stat.use_hist = (mode_q == MODE_HIST) || (p0_q == p1_q);
	assign stat.p0_zero  = p0_q == '0;
	assign stat.w_zero   = w == '0;
	assign stat.falls    = falls;
	assign stat.disc_neg = neg_q;
	assign stat.den_zero = den_q == '0;

	// shared 32x32 multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	assign mul_a = cmd.mul_sq ? p0_q : mslope;
	assign mul_b = cmd.mul_sq ? p0_q : pv;
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_prod)
			prod_q <= mul_p;
		if (cmd.mul_sq)
			sq_q <= mul_p;
	end

	// shared divider
	logic [63:0] div_dvd, div_q;
	logic [32:0] div_dvs, div_r;
	logic        div_done;

	always_comb begin
		case (cmd.div_sel)
			DIV_HIST: begin
				div_dvd = {32'd0, pv};
				div_dvs = {1'b0, p0_q};
			end
			DIV_SLOPE: begin
				div_dvd = prod_q;
				div_dvs = aw;
			end
			DIV_OFF: begin
				div_dvd = {31'd0, pv, 1'b0};
				div_dvs = den_q;
			end
			default: begin
				div_dvd = {32'd0, pv};
				div_dvs = {1'b0, p0_q};
			end
		endcase
	end

	tpis_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);
	assign stat.div_done = div_done;

	// discriminant: pdf0^2 +/- rounded 2*slope*prob/width
	logic [63:0] term;
	logic [64:0] dsum;
	logic        half_up;
	assign half_up = div_r >= (aw - div_r);
	assign term    = div_q[63] ? {64{1'b1}} : ({div_q[62:0], 1'b0} + {63'd0, half_up});
	assign dsum    = {1'b0, sq_q} + {1'b0, term};

	always_ff @(posedge clk) begin
		if (cmd.make_disc) begin
			if (rising) begin
				neg_q  <= 1'b0;
				disc_q <= dsum[64] ? {64{1'b1}} : dsum[63:0];
			end else begin
				neg_q  <= term > sq_q;
				disc_q <= sq_q - term;
			end
		end
	end

	logic        sqrt_done;
	logic [31:0] root;

	tpis_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (disc_q),
		.done     (sqrt_done),
		.root     (root)
	);
	assign stat.sqrt_done = sqrt_done;

	always_ff @(posedge clk) begin
		if (cmd.make_den)
			den_q <= {1'b0, p0_q} + {1'b0, root};
		if (cmd.take_quot)
			off_q <= div_q[32:0];
		else if (cmd.off_zero)
			off_q <= '0;
	end

	// ---------------- sample and clamp ----------------
	logic signed [34:0] v_sum, x1_ext;
	logic [31:0]        v_cl;
	assign v_sum  = {{3{x0_q[31]}}, x0_q} + {2'b00, off_q};
	assign x1_ext = {{3{x1_q[31]}}, x1_q};
	assign v_cl   = (v_sum > x1_ext) ? x1_q : v_sum[31:0];

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.res)
				RES_HIT: begin
					status_q <= STAT_OK;
					value_q  <= hit_x_q;
					index_q  <= hit_idx_q;
				end
				RES_LAST: begin
					status_q <= STAT_OK;
					value_q  <= last_x_q;
					index_q  <= pc_q[IDX_W-1:0] - 8'd1;
				end
				RES_CONT: begin
					status_q <= STAT_OK;
					value_q  <= v_cl;
					index_q  <= lo_q;
				end
				RES_BAD_STATE: begin
					status_q <= STAT_BAD_STATE;
					value_q  <= '0;
					index_q  <= '0;
				end
				default: begin
					status_q <= STAT_BAD_TABLE;
					value_q  <= '0;
					index_q  <= '0;
				end
			endcase
		end
	end

	assign status       = status_q;
	assign sample_value = value_q;
	assign sample_index = index_q;

endmodule

`default_nettype wire

/* design/tpis_ctrl.sv */
// ----------------------------------------------------------------------------
// tpis_ctrl
// Sequencer for load and sample requests; owns the channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tpis_ctrl import tpis_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  req_type,
	output logic       out_valid,
	input  wire logic  out_ready,
	output cmd_t       cmd,
	input  wire stat_t stat
);

	state_t state_q, state_d;
	res_t   res_q, res_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// state register and result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= RES_BAD_TABLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		res_d       = res_q;
		cmd         = '0;
		cmd.rd_sel  = RD_SCAN;
		cmd.div_sel = DIV_HIST;
		cmd.res     = res_q;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = (req_type == REQ_SAMPLE) ? S_CHECK : S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_IDLE;
			end
			S_CHECK: begin
				if (stat.quick_bad) begin
					res_d   = RES_BAD_TABLE;
					state_d = S_EMIT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.rd_sel = RD_LO;
				cmd.lo_fix = 1'b1;
				if (stat.scan_bad) begin
					res_d   = RES_BAD_TABLE;
					state_d = S_EMIT;
				end else if (stat.hit) begin
					res_d   = RES_HIT;
					state_d = S_EMIT;
				end else if (stat.all_disc) begin
					res_d   = RES_LAST;
					state_d = S_EMIT;
				end else begin
					state_d = S_FETCH1;
				end
			end
			S_FETCH1: begin
				cmd.rd_sel   = RD_HI;
				cmd.fetch_lo = 1'b1;
				state_d      = S_FETCH2;
			end
			S_FETCH2: begin
				cmd.fetch_hi = 1'b1;
				state_d      = S_PREP;
			end
			S_PREP: begin
				res_d = RES_CONT;
				if (!stat.prob_pos) begin
					cmd.off_zero = 1'b1;
					state_d      = S_EMIT;
				end else if (stat.use_hist) begin
					if (stat.p0_zero) begin
						res_d   = RES_BAD_STATE;
						state_d = S_EMIT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_HIST;
						state_d       = S_DIV_HIST;
					end
				end else if (stat.w_zero) begin
					if (stat.falls) begin
						res_d = RES_BAD_STATE;
					end else begin
						cmd.off_zero = 1'b1;
					end
					state_d = S_EMIT;
				end else begin
					cmd.mul_prod = 1'b1;
					state_d      = S_MUL_SQ;
				end
			end
			S_MUL_SQ: begin
				cmd.mul_sq    = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SLOPE;
				state_d       = S_DIV_Q;
			end
			S_DIV_Q: begin
				cmd.div_sel = DIV_SLOPE;
				if (stat.div_done) begin
					cmd.make_disc = 1'b1;
					state_d       = S_DISC;
				end
			end
			S_DISC: begin
				if (stat.disc_neg) begin
					res_d   = RES_BAD_STATE;
					state_d = S_EMIT;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d        = S_SQRT;
				end
			end
			S_SQRT: begin
				if (stat.sqrt_done) begin
					cmd.make_den = 1'b1;
					state_d      = S_DEN;
				end
			end
			S_DEN: begin
				if (stat.den_zero) begin
					res_d   = RES_BAD_STATE;
					state_d = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_OFF;
					state_d       = S_DIV_OFF;
				end
			end
			S_DIV_OFF: begin
				cmd.div_sel = DIV_OFF;
				if (stat.div_done) begin
					cmd.take_quot = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_DIV_HIST: begin
				if (stat.div_done) begin
					cmd.take_quot = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* design/tabular_pdf_inverse_sampler_top.sv */
// A sample scans all n points after the transfer, then a histogram bin takes
// one divide and a lin-lin bin two divides and a square root.
// Throughput: one item at a time, set by the table scan and the shared divider;
// the result register lets the next item enter while a result waits.
// Reset clears control, counts and config; table contents stay undefined.
// ----------------------------------------------------------------------------
// tabular_pdf_inverse_sampler_top
// Inverse-cdf sampler over a loaded table of (x, pdf, cdf) points.
// ----------------------------------------------------------------------------
`default_nettype none

module tabular_pdf_inverse_sampler_top import tpis_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               req_type,
	input  wire logic [7:0]         entry_index,
	input  wire logic signed [31:0] entry_abscissa,
	input  wire logic [31:0]        entry_density,
	input  wire logic [31:0]        entry_cumulative,
	input  wire logic [31:0]        uniform_draw,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      sample_value,
	output logic [7:0]              sample_index,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [8:0]         cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// config writes always taken
	assign cfg_ready = 1'b1;

	tpis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tpis_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.entry_index      (entry_index),
		.entry_abscissa   (entry_abscissa),
		.entry_density    (entry_density),
		.entry_cumulative (entry_cumulative),
		.uniform_draw     (uniform_draw),
		.status           (status),
		.sample_value     (sample_value),
		.sample_index     (sample_index)
	);

endmodule

`default_nettype wire

/* design/tpis_checker.sv */
// ----------------------------------------------------------------------------
// tpis_assert
// Port-level assertions for the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpis_assert import tpis_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] sample_value,
	input wire logic [7:0]  sample_index
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
		&& $stable(sample_value) && $stable(sample_index))
		else $error("result changed while stalled");

	// only defined status codes are produced
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STAT_BAD_STATE)
		else $error("undefined status code");

	// error results carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> sample_value == '0 && sample_index == '0)
		else $error("error result with nonzero payload");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

bind tabular_pdf_inverse_sampler_top tpis_assert u_tpis_assert (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.sample_value (sample_value),
	.sample_index (sample_index)
);

`default_nettype wire
